FILE: hw/rtl/iafp_pkg.sv
package iafp_pkg;

    // link and frame layout
    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned RAW_W        = 16;
    localparam int unsigned ANGLE_W      = 18;
    localparam int unsigned OFFSET_W     = 11;
    localparam int unsigned CFG_IDX_W    = 2;
    localparam int unsigned PAYLOAD_N    = 6;
    localparam int unsigned PAYLOAD_IDX_W = 3;
    localparam int unsigned INDEX_W      = 4;
    localparam int unsigned SYNC_W       = 2;

    localparam logic [BYTE_W-1:0]  SYNC_BYTE    = 8'hFF;
    localparam logic [BYTE_W-1:0]  TRAILER_BYTE = 8'hFE;

    // byte_index codes: zero is hunting, one to six payload, seven and eight trailer
    localparam logic [INDEX_W-1:0] IDX_HUNT     = 4'd0;
    localparam logic [INDEX_W-1:0] IDX_FIRST    = 4'd1;
    localparam logic [INDEX_W-1:0] IDX_LAST_PAY = 4'd6;
    localparam logic [INDEX_W-1:0] IDX_TRAIL0   = 4'd7;
    localparam logic [INDEX_W-1:0] IDX_TRAIL1   = 4'd8;

    // raw value of half-degree zero, 180 degrees
    localparam logic [ANGLE_W-1:0] ANGLE_BIAS   = 18'd360;

    typedef logic signed [OFFSET_W-1:0] offset_t;
    typedef logic signed [ANGLE_W-1:0]  angle_t;
    typedef logic [RAW_W-1:0]           raw_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE   = 2'd0,
        CFG_OFFSET_X = 2'd1,
        CFG_OFFSET_Y = 2'd2,
        CFG_OFFSET_Z = 2'd3
    } cfg_idx_t;

    // completed frame handed from the parser to the angle stage
    typedef struct packed {
        logic valid;
        raw_t raw_x;
        raw_t raw_y;
        raw_t raw_z;
    } frame_t;

    typedef struct packed {
        offset_t x;
        offset_t y;
        offset_t z;
    } offsets_t;

endpackage

FILE: hw/rtl/imu_angle_frame_parser.sv
// channel   | direction | handshake               | payload
// rx        | in        | rx_valid / rx_ready     | rx_byte
// angle     | out       | angle_valid / angle_ready | angle_x, angle_y, angle_z
// cfg       | in        | cfg_we (no wait)        | cfg_index, cfg_data
//
// one byte is taken per cycle while rx_ready is high; a byte passes an input
// register and is parsed as it leaves it, and a good frame is written to the result
// register, shown on the angle channel, as its last byte leaves the input register.
// reset clears the hunt state, the valid flags and the configuration registers (parsing off).
// while a result waits unread, a word held in the input register stays there
// and rx_ready follows angle_ready; an empty input register still takes a word.
module imu_angle_frame_parser (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  rx_valid,
    output logic                  rx_ready,
    input  logic [7:0]            rx_byte,
    output logic                  angle_valid,
    input  logic                  angle_ready,
    output logic signed [17:0]    angle_x,
    output logic signed [17:0]    angle_y,
    output logic signed [17:0]    angle_z,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [10:0]           cfg_data
);
    import iafp_pkg::*;

    logic     enable_reg;
    offsets_t offsets_reg;
    frame_t   frame;
    logic     take;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg  <= 1'b0;
            offsets_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_ENABLE:   enable_reg    <= cfg_data[0];
                CFG_OFFSET_X: offsets_reg.x <= offset_t'(cfg_data);
                CFG_OFFSET_Y: offsets_reg.y <= offset_t'(cfg_data);
                CFG_OFFSET_Z: offsets_reg.z <= offset_t'(cfg_data);
                default:      ;
            endcase
        end
    end

    // byte capture and frame parsing
    iafp_parse u_parse (
        .clk      (clk),
        .rst_n    (rst_n),
        .enable   (enable_reg),
        .rx_valid (rx_valid),
        .rx_ready (rx_ready),
        .rx_byte  (rx_byte),
        .take     (take),
        .frame    (frame)
    );

    // angle arithmetic and result register
    iafp_angle u_angle (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame       (frame),
        .offsets     (offsets_reg),
        .take        (take),
        .angle_valid (angle_valid),
        .angle_ready (angle_ready),
        .angle_x     (angle_x),
        .angle_y     (angle_y),
        .angle_z     (angle_z)
    );

endmodule

FILE: hw/rtl/iafp_parse.sv
module iafp_parse (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  enable,
    input  logic                  rx_valid,
    output logic                  rx_ready,
    input  logic [7:0]            rx_byte,
    input  logic                  take,
    output iafp_pkg::frame_t      frame
);
    import iafp_pkg::*;

    logic                      word_valid_reg;
    logic [BYTE_W-1:0]         word_reg;
    logic [SYNC_W-1:0]         sync_count_reg;
    logic [SYNC_W-1:0]         sync_count_next;
    logic [INDEX_W-1:0]        byte_index_reg;
    logic [INDEX_W-1:0]        byte_index_next;
    logic                      trailer_ok_reg;
    logic                      trailer_ok_next;
    logic [BYTE_W-1:0]         payload_reg [PAYLOAD_N];
    logic                      advance;
    logic                      pay_we;
    logic [INDEX_W-1:0]        pay_addr_wide;
    logic [PAYLOAD_IDX_W-1:0]  pay_addr;
    logic [SYNC_W-1:0]         sync_inc;
    logic                      good_frame;

    // the held word moves on whenever the result stage can take a result
    assign advance  = word_valid_reg && take;
    assign rx_ready = !word_valid_reg || take;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_valid_reg <= 1'b0;
        end
        else if (rx_ready)
        begin
            word_valid_reg <= rx_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_valid && rx_ready)
        begin
            word_reg <= rx_byte;
        end
    end

    // sync hunt and frame capture
    assign sync_inc      = sync_count_reg + SYNC_W'(1);
    assign pay_addr_wide = byte_index_reg - IDX_FIRST;
    assign pay_addr      = pay_addr_wide[PAYLOAD_IDX_W-1:0];

    always_comb
    begin
        sync_count_next = sync_count_reg;
        byte_index_next = byte_index_reg;
        trailer_ok_next = trailer_ok_reg;
        pay_we          = 1'b0;
        good_frame      = 1'b0;
        if (advance && enable)
        begin
            if (byte_index_reg == IDX_HUNT)
            begin
                if (word_reg == SYNC_BYTE)
                begin
                    if (sync_inc >= SYNC_W'(2))
                    begin
                        sync_count_next = '0;
                        byte_index_next = IDX_FIRST;
                    end
                    else
                    begin
                        sync_count_next = sync_inc;
                    end
                end
                else
                begin
                    sync_count_next = '0;
                end
            end
            else if (byte_index_reg > IDX_TRAIL1)
            begin
                // stray index, back to hunting
                byte_index_next = IDX_HUNT;
                sync_count_next = '0;
            end
            else if (byte_index_reg <= IDX_LAST_PAY)
            begin
                pay_we          = 1'b1;
                byte_index_next = byte_index_reg + INDEX_W'(1);
            end
            else if (byte_index_reg == IDX_TRAIL0)
            begin
                trailer_ok_next = (word_reg == TRAILER_BYTE);
                byte_index_next = IDX_TRAIL1;
            end
            else
            begin
                good_frame      = trailer_ok_reg && (word_reg == TRAILER_BYTE);
                byte_index_next = IDX_HUNT;
                sync_count_next = '0;
                trailer_ok_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_count_reg <= '0;
            byte_index_reg <= IDX_HUNT;
            trailer_ok_reg <= 1'b0;
        end
        else
        begin
            sync_count_reg <= sync_count_next;
            byte_index_reg <= byte_index_next;
            trailer_ok_reg <= trailer_ok_next;
        end
    end

    // payload bytes, written in arrival order
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < PAYLOAD_N; i++)
        begin
            if (pay_we && (pay_addr == PAYLOAD_IDX_W'(i)))
            begin
                payload_reg[i] <= word_reg;
            end
        end
    end

    // little-endian raw angles
    assign frame.valid = good_frame;
    assign frame.raw_x = {payload_reg[1], payload_reg[0]};
    assign frame.raw_y = {payload_reg[3], payload_reg[2]};
    assign frame.raw_z = {payload_reg[5], payload_reg[4]};

endmodule

FILE: hw/rtl/iafp_angle.sv
module iafp_angle (
    input  logic                  clk,
    input  logic                  rst_n,
    input  iafp_pkg::frame_t      frame,
    input  iafp_pkg::offsets_t    offsets,
    output logic                  take,
    output logic                  angle_valid,
    input  logic                  angle_ready,
    output logic signed [17:0]    angle_x,
    output logic signed [17:0]    angle_y,
    output logic signed [17:0]    angle_z
);
    import iafp_pkg::*;

    logic   valid_reg;
    angle_t x_reg;
    angle_t y_reg;
    angle_t z_reg;
    angle_t x_next;
    angle_t y_next;
    angle_t z_next;

    function automatic angle_t to_angle(input raw_t raw, input offset_t off);
        logic [ANGLE_W-1:0] raw_ext;
        logic [ANGLE_W-1:0] off_ext;
        raw_ext = {{(ANGLE_W-RAW_W){1'b0}}, raw};
        off_ext = {{(ANGLE_W-OFFSET_W){off[OFFSET_W-1]}}, off};
        return angle_t'(raw_ext - ANGLE_BIAS - off_ext);
    endfunction

    // result register frees up when empty or being read
    assign take = !valid_reg || angle_ready;

    // raw minus bias minus axis offset
    assign x_next = to_angle(frame.raw_x, offsets.x);
    assign y_next = to_angle(frame.raw_y, offsets.y);
    assign z_next = to_angle(frame.raw_z, offsets.z);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= frame.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && frame.valid)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign angle_valid = valid_reg;
    assign angle_x     = x_reg;
    assign angle_y     = y_reg;
    assign angle_z     = z_reg;

endmodule

FILE: sim/imu_angle_frame_parser_test.sv
module imu_angle_frame_parser_test;

    import iafp_pkg::*;

    // one angle word as it leaves the block
    typedef struct packed {
        angle_t x;
        angle_t y;
        angle_t z;
    } angles_t;

    // kinds of byte run offered during the random part
    typedef enum logic [1:0] {
        SEG_GOOD,
        SEG_BAD_TRAILER,
        SEG_CUT,
        SEG_NOISE
    } segment_t;

    // rows of the directed script
    typedef enum logic {
        ROW_REG,
        ROW_BYTE
    } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        cfg_idx_t    reg_idx;
        logic [10:0] value;
        logic        typed;
        angles_t     want;
    } script_row_t;

    localparam int SCRIPT_LEN    = 27;
    localparam int RANDOM_ITEMS  = 900;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_AFTER    = 30;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 200000;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                rx_valid;
    logic                rx_ready;
    logic [7:0]          rx_byte;
    logic                angle_valid;
    logic                angle_ready;
    logic signed [17:0]  angle_x;
    logic signed [17:0]  angle_y;
    logic signed [17:0]  angle_z;
    logic                cfg_we;
    logic [1:0]          cfg_index;
    logic [10:0]         cfg_data;

    // parser state as the testbench tracks it
    logic                model_enable;
    offset_t             model_off_x;
    offset_t             model_off_y;
    offset_t             model_off_z;
    logic [1:0]          sync_seen;
    logic [3:0]          frame_pos;
    logic [7:0]          frame_bytes [0:5];
    logic                first_trailer_ok;

    angles_t             angles_due [$];
    script_row_t         script [SCRIPT_LEN];

    int                  fail_count = 0;
    int                  results_seen = 0;
    int                  bytes_fed = 0;
    int                  bytes_parsed = 0;
    int                  settings_applied = 0;
    int                  cycle_count = 0;
    int                  burst_left = 0;
    bit                  gaps_on = 1'b1;

    imu_angle_frame_parser dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx_valid    (rx_valid),
        .rx_ready    (rx_ready),
        .rx_byte     (rx_byte),
        .angle_valid (angle_valid),
        .angle_ready (angle_ready),
        .angle_x     (angle_x),
        .angle_y     (angle_y),
        .angle_z     (angle_z),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // raw minus the half-degree bias minus the axis offset, kept to 18 bits
    function automatic angle_t axis_angle(input raw_t raw, input offset_t off);
        logic signed [19:0] wide;
        wide = $signed({4'b0, raw}) - 20'sd360 - off;
        return wide[17:0];
    endfunction

    // advance the tracked parser by one byte
    task automatic parse_byte(input logic [7:0] b, output bit hit, output angles_t res);
        hit = 1'b0;
        res = '0;
        if (!model_enable)
            return;
        if (frame_pos == IDX_HUNT)
        begin
            // two sync bytes in a row start a frame
            if (b != SYNC_BYTE)
                sync_seen = 2'd0;
            else if (sync_seen == 2'd1)
            begin
                sync_seen = 2'd0;
                frame_pos = IDX_FIRST;
            end
            else
                sync_seen = sync_seen + 2'd1;
        end
        else if (frame_pos <= IDX_LAST_PAY)
        begin
            frame_bytes[frame_pos - IDX_FIRST] = b;
            frame_pos = frame_pos + 4'd1;
        end
        else if (frame_pos == IDX_TRAIL0)
        begin
            first_trailer_ok = (b == TRAILER_BYTE);
            frame_pos = IDX_TRAIL1;
        end
        else
        begin
            // last trailer byte, back to hunting either way
            if (frame_pos == IDX_TRAIL1 && first_trailer_ok && b == TRAILER_BYTE)
            begin
                hit = 1'b1;
                res.x = axis_angle({frame_bytes[1], frame_bytes[0]}, model_off_x);
                res.y = axis_angle({frame_bytes[3], frame_bytes[2]}, model_off_y);
                res.z = axis_angle({frame_bytes[5], frame_bytes[4]}, model_off_z);
            end
            frame_pos = IDX_HUNT;
            sync_seen = 2'd0;
            first_trailer_ok = 1'b0;
        end
    endtask

    // offer one byte, with burst gaps, then record what it should produce
    task automatic feed(input logic [7:0] b, input bit typed, input angles_t want);
        int gap;
        bit hit;
        angles_t pred;
        if (burst_left == 0)
        begin
            gap = gaps_on ? $urandom_range(1, 8) : 0;
            burst_left = $urandom_range(1, 24);
            if (gap != 0)
            begin
                rx_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        rx_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (!rx_ready);
        bytes_fed++;
        if (model_enable)
            bytes_parsed++;
        parse_byte(b, hit, pred);
        if (typed)
            angles_due.push_back(want);
        else if (hit)
            angles_due.push_back(pred);
    endtask

    // drop valid and wait until every angle word is in and the pipe is quiet
    task automatic wait_idle();
        rx_valid <= 1'b0;
        burst_left = 0;
        while (angles_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one register write; the caller lowers cfg_we after the last one
    task automatic write_reg(input cfg_idx_t idx, input logic [10:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            CFG_ENABLE:   model_enable = data[0];
            CFG_OFFSET_X: model_off_x  = data;
            CFG_OFFSET_Y: model_off_y  = data;
            CFG_OFFSET_Z: model_off_z  = data;
            default: ;
        endcase
    endtask

    function automatic raw_t pick_raw();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return raw_t'($urandom);
        endcase
    endfunction

    function automatic offset_t pick_offset();
        case ($urandom_range(0, 3))
            0:       return offset_t'(-1024);
            1:       return offset_t'(1023);
            2:       return offset_t'(0);
            default: return offset_t'($urandom);
        endcase
    endfunction

    function automatic segment_t pick_segment();
        int r;
        r = $urandom_range(0, 9);
        if (r <= 5)
            return SEG_GOOD;
        else if (r == 6)
            return SEG_BAD_TRAILER;
        else if (r == 7)
            return SEG_CUT;
        return SEG_NOISE;
    endfunction

    // a frame with random content, a spoilt or cut frame, or loose bytes
    task automatic send_segment(input segment_t seg);
        logic [7:0] frame [0:9];
        logic [7:0] b;
        raw_t raw;
        int len;
        int n;
        angles_t none;
        none = '0;
        if (seg == SEG_NOISE)
        begin
            n = $urandom_range(1, 4);
            repeat (n)
            begin
                case ($urandom_range(0, 3))
                    0:       b = SYNC_BYTE;
                    1:       b = TRAILER_BYTE;
                    default: b = 8'($urandom);
                endcase
                feed(b, 1'b0, none);
            end
            return;
        end
        frame[0] = SYNC_BYTE;
        frame[1] = SYNC_BYTE;
        for (int a = 0; a < 3; a++)
        begin
            raw = pick_raw();
            frame[2 + 2 * a] = raw[7:0];
            frame[3 + 2 * a] = raw[15:8];
        end
        frame[8] = TRAILER_BYTE;
        frame[9] = TRAILER_BYTE;
        if (seg == SEG_BAD_TRAILER)
        begin
            b = 8'($urandom_range(0, 254));
            if (b == TRAILER_BYTE)
                b = SYNC_BYTE;
            frame[$urandom_range(8, 9)] = b;
        end
        len = (seg == SEG_CUT) ? $urandom_range(1, 9) : 10;
        for (int i = 0; i < len; i++)
            feed(frame[i], 1'b0, none);
    endtask

    function automatic void check_field(input string name, input angle_t want,
                                        input angle_t got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // compare every angle word taken from the block with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && angle_valid && angle_ready)
        begin
            results_seen++;
            if (angles_due.size() == 0)
            begin
                $error("angle word with none expected: %0d %0d %0d",
                       angle_x, angle_y, angle_z);
                fail_count++;
            end
            else
            begin
                check_field("angle_x", angles_due[0].x, angle_x);
                check_field("angle_y", angles_due[0].y, angle_y);
                check_field("angle_z", angles_due[0].z, angle_z);
                void'(angles_due.pop_front());
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("imu_angle_frame_parser: mismatch");
            $finish;
        end
    end

    // receiver: stall pattern of its own, plus one long hold-off
    initial
    begin : receiver
        int hold;
        int pattern_left;
        int tick;
        bit hold_done;
        logic [7:0] mask;
        angle_ready <= 1'b0;
        pattern_left = 0;
        tick = 0;
        hold_done = 1'b0;
        mask = 8'hFF;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (!hold_done && results_seen >= HOLD_AFTER)
            begin
                angle_ready <= 1'b0;
                for (hold = 0; hold < HOLD_CYCLES; hold++)
                    @(posedge clk);
                hold_done = 1'b1;
            end
            if (pattern_left == 0)
            begin
                pattern_left = $urandom_range(16, 64);
                case ($urandom_range(0, 3))
                    0:       mask = 8'hFF;
                    1:       mask = 8'h55;
                    default: mask = 8'($urandom);
                endcase
            end
            pattern_left--;
            angle_ready <= mask[tick % 8];
            tick++;
        end
    end

    // stimulus
    initial
    begin : stimulus
        int phase_len;
        int phase_end;
        rst_n     <= 1'b0;
        rx_valid  <= 1'b0;
        rx_byte   <= 8'h00;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_ENABLE;
        cfg_data  <= 11'h000;
        model_enable     = 1'b0;
        model_off_x      = '0;
        model_off_y      = '0;
        model_off_z      = '0;
        sync_seen        = 2'd0;
        frame_pos        = IDX_HUNT;
        first_trailer_ok = 1'b0;
        for (int i = 0; i < 6; i++)
            frame_bytes[i] = 8'h00;

        // byte while off, extreme offsets, a broken sync, sync bytes as data,
        // extreme raw values, then a frame with a spoilt second trailer
        script = '{
            '{ROW_BYTE, CFG_ENABLE,   11'h0FF, 1'b0, '0},
            '{ROW_REG,  CFG_ENABLE,   11'h001, 1'b0, '0},
            '{ROW_REG,  CFG_OFFSET_X, 11'h400, 1'b0, '0},
            '{ROW_REG,  CFG_OFFSET_Y, 11'h3FF, 1'b0, '0},
            '{ROW_REG,  CFG_OFFSET_Z, 11'h000, 1'b0, '0},
            '{ROW_BYTE, CFG_ENABLE,   11'h0FF, 1'b0, '0},
            '{ROW_BYTE, CFG_ENABLE,   11'h000, 1'b0, '0},
            '{ROW_BYTE, CFG_ENABLE,   11'h0FF, 1'b0, '0},
            '{ROW_BYTE, CFG_ENABLE,   11'h0FF, 1'b0, '0},
            '{ROW_BYTE, CFG_ENABLE,   11'h0FF, 1'b0, '0},
            '{ROW_BYTE, CFG_ENABLE,   11'h0FF, 1'b0, '0},
            '{ROW_BYTE, CFG_ENABLE,   11'h000, 1'b0, '0},
            '{ROW_BYTE, CFG_ENABLE,   11'h000, 1'b0, '0},
            '{ROW_BYTE, CFG_ENABLE,   11'h068, 1'b0, '0},
            '{ROW_BYTE, CFG_ENABLE,   11'h001, 1'b0, '0},
            '{ROW_BYTE, CFG_ENABLE,   11'h0FE, 1'b0, '0},
            '{ROW_BYTE, CFG_ENABLE,   11'h0FE, 1'b1,
              '{18'sd66199, -18'sd1383, 18'sd0}},
            '{ROW_BYTE, CFG_ENABLE,   11'h0FF, 1'b0, '0},
            '{ROW_BYTE, CFG_ENABLE,   11'h0FF, 1'b0, '0},
            '{ROW_BYTE, CFG_ENABLE,   11'h012, 1'b0, '0},
            '{ROW_BYTE, CFG_ENABLE,   11'h034, 1'b0, '0},
            '{ROW_BYTE, CFG_ENABLE,   11'h056, 1'b0, '0},
            '{ROW_BYTE, CFG_ENABLE,   11'h078, 1'b0, '0},
            '{ROW_BYTE, CFG_ENABLE,   11'h09A, 1'b0, '0},
            '{ROW_BYTE, CFG_ENABLE,   11'h0BC, 1'b0, '0},
            '{ROW_BYTE, CFG_ENABLE,   11'h0FE, 1'b0, '0},
            '{ROW_BYTE, CFG_ENABLE,   11'h07E, 1'b0, '0}
        };

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed script
        for (int i = 0; i < SCRIPT_LEN; i++)
        begin
            if (script[i].kind == ROW_REG)
            begin
                if (!cfg_we)
                    wait_idle();
                write_reg(script[i].reg_idx, script[i].value);
                if (i + 1 == SCRIPT_LEN || script[i + 1].kind != ROW_REG)
                begin
                    cfg_we <= 1'b0;
                    settings_applied++;
                end
            end
            else
                feed(script[i].value[7:0], script[i].typed, script[i].want);
        end

        // random phases, each under fresh settings written while idle
        while (bytes_parsed < RANDOM_ITEMS)
        begin
            wait_idle();
            write_reg(CFG_ENABLE, {10'($urandom), ($urandom_range(0, 5) != 0)});
            write_reg(CFG_OFFSET_X, pick_offset());
            write_reg(CFG_OFFSET_Y, pick_offset());
            write_reg(CFG_OFFSET_Z, pick_offset());
            cfg_we <= 1'b0;
            settings_applied++;
            gaps_on = ($urandom_range(0, 3) != 0);
            phase_len = model_enable ? $urandom_range(40, 120) : $urandom_range(4, 12);
            phase_end = bytes_fed + phase_len;
            while (bytes_fed < phase_end)
                send_segment(pick_segment());
        end

        wait_idle();
        $display("fed %0d bytes (%0d parsed with the parser on) under %0d register settings",
                 bytes_fed, bytes_parsed, settings_applied);
        $display("checked %0d angle words", results_seen);
        if (fail_count == 0)
            $display("imu_angle_frame_parser: match");
        else
            $display("imu_angle_frame_parser: mismatch");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/iafp_pkg.sv
hw/rtl/iafp_parse.sv
hw/rtl/iafp_angle.sv
hw/rtl/imu_angle_frame_parser.sv
sim/imu_angle_frame_parser_test.sv
